### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CFP_ASSERT_NOW(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("cfp assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CFP_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("cfp assertion failed");

`endif

### design/cfp_pkg.sv
`timescale 1ns / 1ps

package cfp_pkg;

    localparam int VALUE_BYTES_DEF = 2;
    localparam logic [7:0] FRAME_LENGTH_RESET = 8'd9;
    localparam logic [7:0] MIN_FRAME_LENGTH = 8'd5;

    // frame delimiters
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;

    // command letters
    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_P = 8'h50;
    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_L = 8'h4C;

    // command codes
    localparam logic [3:0] CMD_IDLE     = 4'd0;
    localparam logic [3:0] CMD_SET_FREQ = 4'd1;
    localparam logic [3:0] CMD_SET_TEMP = 4'd2;
    localparam logic [3:0] CMD_P        = 4'd3;
    localparam logic [3:0] CMD_I        = 4'd4;
    localparam logic [3:0] CMD_D        = 4'd5;
    localparam logic [3:0] CMD_PID      = 4'd6;
    localparam logic [3:0] CMD_BED_HEAT = 4'd7;
    localparam logic [3:0] CMD_LOCK     = 4'd8;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  command;
        logic [15:0] value_word;
        logic [7:0]  value_count;
    } result_t;

endpackage

### design/cfp_byte_if.sv
`timescale 1ns / 1ps

interface cfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

### design/cfp_result_if.sv
`timescale 1ns / 1ps

interface cfp_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [3:0]  command;
    logic [15:0] value_word;
    logic [7:0]  value_count;

    modport source (output valid, output status, output command, output value_word,
                    output value_count, input ready);
    modport sink   (input valid, input status, input command, input value_word,
                    input value_count, output ready);
endinterface

### design/cfp_frame_core.sv
`timescale 1ns / 1ps

module cfp_frame_core
    import cfp_pkg::*;
#(
    parameter int VALUE_BYTES = VALUE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    input  logic [7:0] frame_length,
    output logic       res_fire,
    output result_t    res
);

    localparam int IDX_W = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
    localparam logic [7:0] VB_LIMIT = 8'(VALUE_BYTES);

    function automatic logic [3:0] letter_code(input logic [7:0] b, input logic [3:0] keep);
        logic [3:0] code;
        case (b)
            CHAR_S:  code = CMD_SET_FREQ;
            CHAR_T:  code = CMD_SET_TEMP;
            CHAR_P:  code = CMD_P;
            CHAR_I:  code = CMD_I;
            CHAR_D:  code = CMD_D;
            CHAR_R:  code = CMD_PID;
            CHAR_B:  code = CMD_BED_HEAT;
            CHAR_L:  code = CMD_LOCK;
            default: code = keep;
        endcase
        return code;
    endfunction

    logic [7:0] pos_reg, pos_next;
    logic       ok_reg, ok_next;
    phase_t     phase_reg, phase_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [3:0] pcmd_reg, pcmd_next;
    logic [3:0] scmd_reg, scmd_next;
    logic [7:0] pval_reg [VALUE_BYTES];
    logic [7:0] pval_next [VALUE_BYTES];
    logic [7:0] sval_reg [VALUE_BYTES];
    logic [7:0] sval_next [VALUE_BYTES];

    logic [7:0] pos;
    logic       first;
    logic       len_ok;
    logic       bad;
    logic       last;
    logic       pass;
    logic [7:0] out_val [VALUE_BYTES];
    logic [7:0] word_lo;

    always_comb
    begin
        pos    = frame_start ? 8'd0 : pos_reg;
        first  = (pos == 8'd0);
        len_ok = (frame_length >= MIN_FRAME_LENGTH);
        last   = (frame_length != 8'd0) && (pos == frame_length - 8'd1);

        bad = (first && rx_byte != CHAR_LPAREN)
            | (pos == 8'd1 && rx_byte != CHAR_LBRACE)
            | (pos == 8'd2 && (!len_ok || rx_byte != frame_length - 8'd5))
            | (frame_length >= 8'd2 && pos == frame_length - 8'd2 && rx_byte != CHAR_RBRACE)
            | (last && rx_byte != CHAR_RPAREN);

        // per-frame state restarts at position zero
        ok_next    = (first ? 1'b1 : ok_reg) && !bad;
        phase_next = first ? PH_WAIT : phase_reg;
        cnt_next   = first ? 8'd0 : cnt_reg;
        pcmd_next  = first ? scmd_reg : pcmd_reg;
        for (int k = 0; k < VALUE_BYTES; k++)
        begin
            pval_next[k] = first ? sval_reg[k] : pval_reg[k];
        end

        if (pos == 8'd3)
        begin
            pcmd_next = letter_code(rx_byte, pcmd_next);
        end

        if (pos >= 8'd3)
        begin
            case (phase_next)
                PH_WAIT:
                begin
                    if (rx_byte == CHAR_COLON)
                    begin
                        phase_next = PH_COLLECT;
                    end
                end
                PH_COLLECT:
                begin
                    if (rx_byte == CHAR_RBRACE)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        if (cnt_next < VB_LIMIT)
                        begin
                            pval_next[cnt_next[IDX_W-1:0]] = rx_byte;
                        end
                        if (cnt_next != 8'd255)
                        begin
                            cnt_next = cnt_next + 8'd1;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_next;
                end
            endcase
        end

        pass     = ok_next && len_ok;
        pos_next = last ? 8'd0 : pos + 8'd1;

        scmd_next = scmd_reg;
        for (int k = 0; k < VALUE_BYTES; k++)
        begin
            sval_next[k] = sval_reg[k];
        end
        if (last && pass)
        begin
            scmd_next = pcmd_next;
            for (int k = 0; k < VALUE_BYTES; k++)
            begin
                sval_next[k] = pval_next[k];
            end
        end

        for (int k = 0; k < VALUE_BYTES; k++)
        begin
            out_val[k] = sval_next[k];
        end
    end

    generate
        if (VALUE_BYTES > 1)
        begin : g_two_bytes
            assign word_lo = out_val[1];
        end
        else
        begin : g_one_byte
            assign word_lo = 8'd0;
        end
    endgenerate

    assign res_fire        = accept && last;
    assign res.status      = !pass;
    assign res.command     = scmd_next;
    assign res.value_word  = {out_val[0], word_lo};
    assign res.value_count = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 8'd0;
            ok_reg    <= 1'b1;
            phase_reg <= PH_WAIT;
            cnt_reg   <= 8'd0;
            pcmd_reg  <= CMD_IDLE;
            scmd_reg  <= CMD_IDLE;
            for (int k = 0; k < VALUE_BYTES; k++)
            begin
                pval_reg[k] <= 8'd0;
                sval_reg[k] <= 8'd0;
            end
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            ok_reg    <= ok_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            pcmd_reg  <= pcmd_next;
            scmd_reg  <= scmd_next;
            for (int k = 0; k < VALUE_BYTES; k++)
            begin
                pval_reg[k] <= pval_next[k];
                sval_reg[k] <= sval_next[k];
            end
        end
    end

endmodule

### design/command_frame_parser_unit.sv
`timescale 1ns / 1ps
// channel       dir  payload                                        handshake
// byte_chan     in   rx_byte[7:0], frame_start                      valid/ready
// result_chan   out  status, command[3:0], value_word[15:0],        valid/ready
//                    value_count[7:0]
// cfg           in   cfg_wdata[7:0] = frame_length                  cfg_we
//
// one byte item per cycle while byte_chan.ready is high; the frame state is
// updated at the accepting edge and a frame's result is registered at its last byte
// rst_n is asynchronous, active low: position 0, command idle, values 0,
// frame_length 9
// a two-entry output stage (result register plus skid register) lets bytes
// flow while a result waits; byte_chan.ready drops only when both hold items

module command_frame_parser_unit
    import cfp_pkg::*;
#(
    parameter int VALUE_BYTES = VALUE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    cfp_byte_if.sink   byte_chan,
    cfp_result_if.source result_chan,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    // configuration register
    logic [7:0] frame_length_reg;

    // output stage: main result register and skid register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    logic    accept;
    logic    drain;
    logic    res_fire;
    result_t res;

    // ready is a register output: low only while the skid entry is taken
    assign byte_chan.ready = !skid_valid_reg;
    assign accept          = byte_chan.valid && byte_chan.ready;
    assign drain           = out_valid_reg && result_chan.ready;

    cfp_frame_core #(
        .VALUE_BYTES (VALUE_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (byte_chan.rx_byte),
        .frame_start  (byte_chan.frame_start),
        .frame_length (frame_length_reg),
        .res_fire     (res_fire),
        .res          (res)
    );

    // user must write frame_length only while the block is idle; not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            frame_length_reg <= cfg_wdata;
        end
    end

    // output stage steering
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (drain)
        begin
            if (skid_valid_reg)
            begin
                // skid moves up; no new result can arrive, ready was low
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_fire;
                if (res_fire)
                begin
                    out_data_next = res;
                end
            end
        end
        else if (res_fire)
        begin
            if (out_valid_reg)
            begin
                // result register still waiting: park the new item
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result_chan.valid       = out_valid_reg;
    assign result_chan.status      = out_data_reg.status;
    assign result_chan.command     = out_data_reg.command;
    assign result_chan.value_word  = out_data_reg.value_word;
    assign result_chan.value_count = out_data_reg.value_count;

endmodule

### design/cfp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfp_checker
    import cfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status,
    input logic [3:0]  command,
    input logic [15:0] value_word,
    input logic [7:0]  value_count
);

    // a stalled result keeps its payload
    `CFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(command)
        && $stable(value_word) && $stable(value_count))

    // bytes are refused only while a result is waiting
    `CFP_ASSERT_NOW(a_ready_low_has_result, !in_ready, out_valid)

    // with both entries full and no drain the stage stays full
    `CFP_ASSERT_NEXT(a_full_stays, !in_ready && !out_ready, !in_ready)

    // command codes stay in the defined range
    `CFP_ASSERT_NOW(a_command_range, out_valid, command <= CMD_LOCK)

endmodule

bind command_frame_parser_unit cfp_checker u_cfp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (byte_chan.ready),
    .out_valid   (result_chan.valid),
    .out_ready   (result_chan.ready),
    .status      (result_chan.status),
    .command     (result_chan.command),
    .value_word  (result_chan.value_word),
    .value_count (result_chan.value_count)
);
